// ===== rtl/core/fvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// fvsm_pkg: shared types and constants for the four-voice sound mixer
// Fixed-point widths, sequencer states and the step bundle between units.
// ----------------------------------------------------------------------------
package fvsm_pkg;

  localparam int PhaseBits  = 24;
  localparam int SampleBits = 16;
  localparam int SamplePer  = 95;
  localparam int OutRate    = 44100;
  localparam int DivBits    = 48;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ1_DIV,
    ST_SQ2,
    ST_SQ2_DIV,
    ST_WAVE,
    ST_WAVE_DIV,
    ST_NOISE,
    ST_NOISE_DIV,
    ST_LFSR,
    ST_MIX,
    ST_FILT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DivBits-1:0] num;
    logic [DivBits-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/core/fvsm_div.sv =====
// ----------------------------------------------------------------------------
// fvsm_div: bit-serial restoring divider
// One quotient bit per cycle; used for every phase increment.
// ----------------------------------------------------------------------------
module fvsm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fvsm_pkg::div_req_t           req,
  output logic                         done,
  output logic [fvsm_pkg::DivBits-1:0] quot
);
  import fvsm_pkg::*;

  logic [DivBits-1:0] q_r, q_nxt;
  logic [DivBits:0]   rem_r, rem_nxt;
  logic [DivBits-1:0] den_r, den_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [DivBits:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DivBits-1:0], q_r[DivBits-1]};
    if (req.start) begin
      q_nxt    = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'(DivBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[DivBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DivBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign quot = q_nxt;
endmodule

// ===== rtl/core/four_voice_sound_mixer_highpass.sv =====
// ----------------------------------------------------------------------------
// four_voice_sound_mixer_highpass: four-voice sound generator with DC block
// Register copy, per-sample sequencer, serial divider and high-pass filter.
// ----------------------------------------------------------------------------
// channel | ports                                   | dir
// in      | in_valid in_ready in_func in_cycles ... | in
// out     | out_valid out_ready out_sample out_last | out
// A write request is served in ST_IDLE; a tick with no sample passes ST_OUT.
// Each sample runs four serial divisions, each after a set-up state (a muted
// voice skips its division), then LFSR steps, mix, filter and a decision state.
// Reset clears all state but the output payload, in_r, fbp_r and the divider
// datapath. A sample waiting on out_ready holds only the filter stage; the
// next request is taken once the last sample is staged.
module four_voice_sound_mixer_highpass (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_cycles,
  input  logic [5:0]  in_reg_index,
  input  logic [7:0]  in_reg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_sample,
  output logic        out_last
);
  import fvsm_pkg::*;

  state_t st_r, st_nxt;
  logic [7:0]  regs_r [32];
  logic [7:0]  wave_r [16];
  logic [6:0]  rem_r;
  logic [8:0]  acc_r, acc_nxt;
  logic [1:0]  nsmp_r;
  logic [PhaseBits-1:0] ph1_r, ph2_r, phw_r, phn_r;
  logic [14:0] lfsr_r;
  logic [3:0]  steps_r;
  logic signed [17:0] sum_r;
  logic signed [15:0] pin_r, pout_r, in_r;
  logic signed [33:0] fbp_r;
  logic        ov_r;
  logic signed [15:0] os_r;
  logic        ol_r;
  div_req_t    dreq;
  logic        ddone;
  logic [DivBits-1:0] dq;

  fvsm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  // register fields
  logic [3:0]  vol1, vol2, voln;
  logic [10:0] f1, f2, fw;
  logic [1:0]  wcode;
  logic        wave_on;
  logic [3:0]  nsh;
  logic [2:0]  ndc;
  logic [7:0]  ndiv;
  assign vol1 = regs_r[2][7:4];
  assign vol2 = regs_r[7][7:4];
  assign voln = regs_r[17][7:4];
  assign f1 = {regs_r[4][2:0], regs_r[3]};
  assign f2 = {regs_r[9][2:0], regs_r[8]};
  assign fw = {regs_r[14][2:0], regs_r[13]};
  assign wcode = regs_r[12][6:5];
  assign wave_on = regs_r[10][7] && (wcode != 2'd0);
  assign nsh = regs_r[18][7:4];
  assign ndc = regs_r[18][2:0];
  assign ndiv = (ndc == 3'd0) ? 8'd8 : {1'b0, ndc, 4'd0};

  function automatic logic [PhaseBits-1:0] thr(input logic [1:0] d);
    case (d)
      2'd0: thr = 24'h200000;
      2'd1: thr = 24'h400000;
      2'd2: thr = 24'h800000;
      default: thr = 24'hC00000;
    endcase
  endfunction

  // k/15 of full scale, rounded half away from zero
  function automatic logic signed [17:0] lvl15(input logic [3:0] k);
    case (k)
      4'd0:  lvl15 = 18'sd0;
      4'd1:  lvl15 = 18'sd2185;
      4'd2:  lvl15 = 18'sd4369;
      4'd3:  lvl15 = 18'sd6554;
      4'd4:  lvl15 = 18'sd8738;
      4'd5:  lvl15 = 18'sd10923;
      4'd6:  lvl15 = 18'sd13107;
      4'd7:  lvl15 = 18'sd15292;
      4'd8:  lvl15 = 18'sd17476;
      4'd9:  lvl15 = 18'sd19661;
      4'd10: lvl15 = 18'sd21845;
      4'd11: lvl15 = 18'sd24030;
      4'd12: lvl15 = 18'sd26214;
      4'd13: lvl15 = 18'sd28399;
      4'd14: lvl15 = 18'sd30583;
      default: lvl15 = 18'sd32768;
    endcase
  endfunction

  // k/75 of full scale, rounded half away from zero
  function automatic logic signed [17:0] lvl75(input logic [3:0] k);
    case (k)
      4'd0:  lvl75 = 18'sd0;
      4'd1:  lvl75 = 18'sd437;
      4'd2:  lvl75 = 18'sd874;
      4'd3:  lvl75 = 18'sd1311;
      4'd4:  lvl75 = 18'sd1748;
      4'd5:  lvl75 = 18'sd2185;
      4'd6:  lvl75 = 18'sd2621;
      4'd7:  lvl75 = 18'sd3058;
      4'd8:  lvl75 = 18'sd3495;
      4'd9:  lvl75 = 18'sd3932;
      4'd10: lvl75 = 18'sd4369;
      4'd11: lvl75 = 18'sd4806;
      4'd12: lvl75 = 18'sd5243;
      4'd13: lvl75 = 18'sd5680;
      4'd14: lvl75 = 18'sd6117;
      default: lvl75 = 18'sd6554;
    endcase
  endfunction

  // n/20 rounded half away from zero; /5 by reciprocal, exact for |n| < 2^17
  function automatic logic signed [17:0] round_div20(input logic signed [17:0] n);
    logic [17:0] a;
    logic [15:0] z;
    logic [31:0] p;
    begin
      a = n[17] ? 18'(-n) : 18'(n);
      z = 16'((19'(a) + 19'd10) >> 2);
      p = 32'(z) * 32'd26215;
      round_div20 = n[17] ? -18'(p[29:17]) : 18'(p[29:17]);
    end
  endfunction

  logic [PhaseBits-1:0] ph1a, ph2a, phwa;
  logic [PhaseBits:0]   phna;
  logic [4:0]  widx;
  logic [7:0]  wbyte;
  logic [3:0]  wnib;
  logic [3:0]  wmag;
  logic signed [17:0] lv1, lv2, lvw, lvn;
  logic [14:0] lfsr_st;
  logic        lx;
  assign ph1a = ph1_r + dq[PhaseBits-1:0];
  assign ph2a = ph2_r + dq[PhaseBits-1:0];
  assign phwa = phw_r + dq[PhaseBits-1:0];
  assign phna = {1'b0, phn_r} + {1'b0, dq[PhaseBits-1:0]};
  assign widx = phwa[PhaseBits-1 -: 5];
  assign wbyte = wave_r[widx[4:1]];
  assign wnib = (widx[0] ? wbyte[3:0] : wbyte[7:4]) >> (wcode - 2'd1);
  // |2w-15| is always odd
  assign wmag = {wnib[3] ? wnib[2:0] : ~wnib[2:0], 1'b1};
  assign lv1 = lvl15(vol1);
  assign lv2 = lvl15(vol2);
  assign lvw = wnib[3] ? lvl15(wmag) : -lvl15(wmag);
  assign lvn = lvl75(voln);
  assign lx = lfsr_r[0] ^ lfsr_r[1];
  always_comb begin
    lfsr_st = {lx, lfsr_r[14:1]};
    if (regs_r[18][3]) lfsr_st[6] = lx;
  end

  // mix and filter
  logic signed [17:0] mixq;
  logic signed [33:0] fbsh;
  logic signed [17:0] fout;
  logic signed [15:0] fsat;
  assign mixq = round_div20(sum_r);
  assign fbsh = (fbp_r + 34'sd32768) >>> 16;
  assign fout = 18'(in_r) - 18'(pin_r) + 18'(fbsh);
  assign fsat = (fout > 18'sd32767) ? 16'sh7FFF :
                (fout < -18'sd32768) ? 16'sh8000 : 16'(fout);

  assign in_ready = (st_r == ST_IDLE);
  logic acc_in;
  assign acc_in = in_valid && in_ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:      if (acc_in && !in_func) st_nxt = ST_OUT;
      ST_SQ1:       st_nxt = ST_SQ1_DIV;
      ST_SQ1_DIV:   if (vol1 == 4'd0 || ddone) st_nxt = ST_SQ2;
      ST_SQ2:       st_nxt = ST_SQ2_DIV;
      ST_SQ2_DIV:   if (vol2 == 4'd0 || ddone) st_nxt = ST_WAVE;
      ST_WAVE:      st_nxt = ST_WAVE_DIV;
      ST_WAVE_DIV:  if (!wave_on || ddone) st_nxt = ST_NOISE;
      ST_NOISE:     st_nxt = ST_NOISE_DIV;
      ST_NOISE_DIV: if (voln == 4'd0) st_nxt = ST_MIX;
                    else if (ddone) st_nxt = ST_LFSR;
      ST_LFSR:      if (steps_r == 4'd0) st_nxt = ST_MIX;
      ST_MIX:       st_nxt = ST_FILT;
      ST_FILT:      if (!ov_r || out_ready) st_nxt = ST_OUT;
      ST_OUT: begin
        if (acc_r >= 9'(SamplePer) && nsmp_r != 2'd3) st_nxt = ST_SQ1;
        else st_nxt = ST_IDLE;
      end
      default:      st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = '0;
    case (st_r)
      ST_SQ1: begin
        dreq.start = vol1 != 4'd0;
        dreq.num = 48'(64'd131072 << PhaseBits);
        dreq.den = 48'((12'd2048 - 12'(f1)) * OutRate);
      end
      ST_SQ2: begin
        dreq.start = vol2 != 4'd0;
        dreq.num = 48'(64'd131072 << PhaseBits);
        dreq.den = 48'((12'd2048 - 12'(f2)) * OutRate);
      end
      ST_WAVE: begin
        dreq.start = wave_on;
        dreq.num = 48'(64'd65536 << PhaseBits);
        dreq.den = 48'((12'd2048 - 12'(fw)) * OutRate);
      end
      ST_NOISE: begin
        dreq.start = voln != 4'd0;
        dreq.num = 48'(64'd4194304 << PhaseBits);
        dreq.den = 48'(40'(ndiv) * 40'(OutRate)) << nsh;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (st_r == ST_IDLE && acc_in && !in_func) acc_nxt = 9'(rem_r) + 9'(in_cycles);
    else if (st_r == ST_SQ1) acc_nxt = acc_r - 9'(SamplePer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      for (int i = 0; i < 32; i++) regs_r[i] <= '0;
      for (int i = 0; i < 16; i++) wave_r[i] <= '0;
      rem_r <= '0; acc_r <= '0; nsmp_r <= '0;
      ph1_r <= '0; ph2_r <= '0; phw_r <= '0; phn_r <= '0;
      lfsr_r <= 15'h7FFF; pin_r <= '0; pout_r <= '0;
      ov_r <= 1'b0; steps_r <= '0; sum_r <= '0;
    end else begin
      st_r <= st_nxt;
      acc_r <= acc_nxt;
      if (st_r == ST_FILT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (acc_in) begin
          if (in_func) begin
            if (in_reg_index < 6'd32) regs_r[in_reg_index[4:0]] <= in_reg_data;
            else if (in_reg_index < 6'd48) wave_r[in_reg_index[3:0]] <= in_reg_data;
          end else begin
            nsmp_r <= '0;
          end
        end
        ST_SQ1: sum_r <= '0;
        ST_SQ1_DIV: if (vol1 != 4'd0 && ddone) begin
          ph1_r <= ph1a;
          sum_r <= sum_r + ((ph1a < thr(regs_r[1][7:6])) ? lv1 : -lv1);
        end
        ST_SQ2_DIV: if (vol2 != 4'd0 && ddone) begin
          ph2_r <= ph2a;
          sum_r <= sum_r + ((ph2a < thr(regs_r[6][7:6])) ? lv2 : -lv2);
        end
        ST_WAVE_DIV: if (wave_on && ddone) begin
          phw_r <= phwa;
          sum_r <= sum_r + lvw;
        end
        ST_NOISE_DIV: if (voln != 4'd0 && ddone) begin
          phn_r <= phna[PhaseBits-1:0];
          steps_r <= 4'(dq[DivBits-1:PhaseBits] + 48'(phna[PhaseBits]));
        end
        ST_LFSR: begin
          if (steps_r != 4'd0) begin
            lfsr_r <= lfsr_st;
            steps_r <= steps_r - 4'd1;
          end else begin
            sum_r <= sum_r + (lfsr_r[0] ? -lvn : lvn);
          end
        end
        ST_MIX: begin
          in_r <= 16'(mixq);
          fbp_r <= 34'sd65209 * 34'(pout_r);
        end
        ST_FILT: if (!ov_r || out_ready) begin
          pin_r <= in_r;
          pout_r <= fsat;
          os_r <= fsat;
          ol_r <= !(acc_r >= 9'(SamplePer) && nsmp_r != 2'd2);
          nsmp_r <= nsmp_r + 2'd1;
        end
        ST_OUT: if (st_nxt == ST_IDLE) begin
          // below one period here, whatever the tick
          rem_r <= 7'(acc_r);
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_sample = os_r;
  assign out_last = ol_r;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
    else $error("out payload changed");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < 7'(SamplePer)) else $error("remainder range");
`endif
endmodule
